/* rtl/mslm_pkg.sv */
// Package for the multi-string line matcher: opcodes, register indexes, constants,
// word and control structs, and the case-folding function.
// No dependencies.
package mslm_pkg;

  localparam int MAX_ALTS_DEFAULT = 8;
  localparam int MAX_LEN_DEFAULT  = 64;

  localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0]  UPPER_A      = 8'h41;
  localparam logic [7:0]  UPPER_Z      = 8'h5A;
  localparam logic [7:0]  FOLD_OFFSET  = 8'h20;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_LOAD_BYTE = 2'd0;
  localparam logic [1:0] OP_SET_LEN   = 2'd1;
  localparam logic [1:0] OP_TEXT      = 2'd2;
  localparam logic [1:0] OP_NEW_FILE  = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_ALTS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CASE_FOLD  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_STOP_FIRST = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] alt_index;
    logic [5:0] position;
    logic [7:0] value;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic        line_matched;
    logic [2:0]  matched_alternative;
    logic [31:0] line_number;
    logic [31:0] matching_lines;
  } result_t;

  typedef struct packed {
    logic       text;
    logic       restart;
    logic       close;
    logic       newline;
    logic [7:0] text_byte;
  } step_t;

  typedef struct packed {
    logic       load_byte;
    logic       set_len;
    logic [2:0] alt_index;
    logic [5:0] position;
    logic [7:0] value;
  } pat_wr_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    if (en && (b >= UPPER_A) && (b <= UPPER_Z)) begin
      return b + FOLD_OFFSET;
    end
    return b;
  endfunction

endpackage

/* rtl/mslm_if.sv */
// Valid/ready channel interfaces for the line matcher: input words and result words.
// Depends on nothing; payload fields follow the block's item and result formats.
interface mslm_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] alt_index;
  logic [5:0] position;
  logic [7:0] value;
  logic       end_of_text;

  modport source (output valid, opcode, alt_index, position, value, end_of_text,
                  input ready);
  modport sink (input valid, opcode, alt_index, position, value, end_of_text,
                output ready);
endinterface

interface mslm_result_if;
  logic        valid;
  logic        ready;
  logic        line_matched;
  logic [2:0]  matched_alternative;
  logic [31:0] line_number;
  logic [31:0] matching_lines;

  modport source (output valid, line_matched, matched_alternative, line_number,
                  matching_lines, input ready);
  modport sink (input valid, line_matched, matched_alternative, line_number,
                matching_lines, output ready);
endinterface

/* rtl/mslm_pattern_store.sv */
// Pattern memory, alternative lengths and the per-alternative reversed compare rows.
// A nonzero length write copies the pattern from memory into its row. Uses mslm_pkg.
module mslm_pattern_store #(
  parameter int MAX_ALTS = mslm_pkg::MAX_ALTS_DEFAULT,
  parameter int MAX_LEN  = mslm_pkg::MAX_LEN_DEFAULT,
  parameter int AIW      = 3,
  parameter int LIW      = 6,
  parameter int LENW     = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  mslm_pkg::pat_wr_t pw,
  output logic [7:0]        rev [MAX_ALTS][MAX_LEN],
  output logic [LENW-1:0]   lens [MAX_ALTS],
  output logic              busy
);

  localparam int DEPTH = MAX_ALTS * (1 << LIW);

  logic [7:0]      mem [DEPTH];
  logic [7:0]      rd_data;
  logic [7:0]      alt8;
  logic [7:0]      pos8;
  logic            alt_ok;
  logic            pos_ok;
  logic [AIW-1:0]  alt_i;
  logic [LIW-1:0]  pos_i;
  logic [LENW-1:0] new_len;
  logic [LENW-1:0] cur_len;
  logic [7:0]      direct_idx;
  logic            active;
  logic [AIW-1:0]  sweep_alt;
  logic [LENW-1:0] sweep_len;
  logic [LENW-1:0] cnt;
  logic            rq_valid;
  logic [LENW-1:0] rq_pos;
  logic [LENW-1:0] sweep_idx;

  assign alt8       = {5'b0, pw.alt_index};
  assign pos8       = {2'b0, pw.position};
  assign alt_ok     = alt8 < 8'(MAX_ALTS);
  assign pos_ok     = pos8 < 8'(MAX_LEN);
  assign alt_i      = alt8[AIW-1:0];
  assign pos_i      = pos8[LIW-1:0];
  assign new_len    = (pw.value <= 8'(MAX_LEN)) ? pw.value[LENW-1:0] : '0;
  assign cur_len    = lens[alt_i];
  assign direct_idx = 8'(cur_len) - 8'd1 - pos8;
  assign sweep_idx  = sweep_len - LENW'(1) - rq_pos;
  assign busy       = active;

  always_ff @(posedge clk) begin
    if (pw.load_byte && alt_ok && pos_ok) begin
      mem[{alt_i, pos_i}] <= pw.value;
    end
    rd_data <= mem[{sweep_alt, cnt[LIW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < MAX_ALTS; a++) begin
        lens[a] <= '0;
      end
    end else if (pw.set_len && alt_ok) begin
      lens[alt_i] <= new_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      rq_valid  <= 1'b0;
      sweep_alt <= '0;
      sweep_len <= '0;
      cnt       <= '0;
    end else if (pw.set_len && alt_ok && (new_len != '0)) begin
      active    <= 1'b1;
      rq_valid  <= 1'b0;
      sweep_alt <= alt_i;
      sweep_len <= new_len;
      cnt       <= '0;
    end else if (active) begin
      if (cnt < sweep_len) begin
        cnt      <= cnt + LENW'(1);
        rq_valid <= 1'b1;
      end else begin
        rq_valid <= 1'b0;
        if (!rq_valid) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rq_pos <= cnt;
    if (pw.load_byte && alt_ok && pos_ok && (pos8 < 8'(cur_len))) begin
      rev[alt_i][direct_idx[LIW-1:0]] <= pw.value;
    end else if (rq_valid) begin
      rev[sweep_alt][sweep_idx[LIW-1:0]] <= rd_data;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    active |-> (cnt <= sweep_len))
    else $error("copy counter ran past the alternative length");
  a_read_in_copy: assert property (@(posedge clk) disable iff (rst)
    rq_valid |-> active)
    else $error("pattern read returned outside a copy");
`endif

endmodule

/* rtl/mslm_matcher.sv */
// Text window, line fill count and the parallel compare of all alternatives.
// Uses mslm_pkg; compare rows and lengths come from mslm_pattern_store.
module mslm_matcher #(
  parameter int MAX_ALTS = mslm_pkg::MAX_ALTS_DEFAULT,
  parameter int MAX_LEN  = mslm_pkg::MAX_LEN_DEFAULT,
  parameter int LENW     = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  mslm_pkg::step_t   step,
  input  logic              case_fold,
  input  logic [3:0]        num_alts,
  input  logic [7:0]        rev [MAX_ALTS][MAX_LEN],
  input  logic [LENW-1:0]   lens [MAX_ALTS],
  output logic              found,
  output logic [2:0]        found_alt
);

  logic [7:0]      win [MAX_LEN];
  logic [7:0]      w_new [MAX_LEN];
  logic [LENW-1:0] fill;
  logic [LENW-1:0] fill_inc;
  logic            all_eq;

  assign fill_inc = (fill == LENW'(MAX_LEN)) ? fill : fill + LENW'(1);

  always_comb begin
    w_new[0] = step.text_byte;
    for (int i = 1; i < MAX_LEN; i++) begin
      w_new[i] = win[i-1];
    end
  end

  always_comb begin
    found     = 1'b0;
    found_alt = '0;
    all_eq    = 1'b1;
    for (int a = 0; a < MAX_ALTS; a++) begin
      all_eq = 1'b1;
      for (int i = 0; i < MAX_LEN; i++) begin
        if ((LENW'(i) < lens[a]) &&
            (w_new[i] != mslm_pkg::fold_byte(rev[a][i], case_fold))) begin
          all_eq = 1'b0;
        end
      end
      if (all_eq && (lens[a] != '0) && (lens[a] <= fill_inc) &&
          (5'(a) < {1'b0, num_alts}) && !step.newline) begin
        found     = 1'b1;
        found_alt = 3'(a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step.text) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        win[i] <= w_new[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || step.restart) begin
      fill <= '0;
    end else if (step.text) begin
      if (step.close || step.newline) begin
        fill <= '0;
      end else begin
        fill <= fill_inc;
      end
    end
  end

endmodule

/* rtl/mslm_line_tracker.sv */
// Per-line hit state, line and match counters, stop flag and result word assembly.
// Uses mslm_pkg; takes the compare outcome from mslm_matcher.
module mslm_line_tracker (
  input  logic              clk,
  input  logic              rst,
  input  mslm_pkg::step_t   step,
  input  logic              stop_first,
  input  logic              found,
  input  logic [2:0]        found_alt,
  output mslm_pkg::result_t res
);

  logic        line_hit;
  logic [2:0]  hit_alt;
  logic [31:0] line_cnt;
  logic [31:0] match_cnt;
  logic        stopped;
  logic        hit_eff;
  logic [2:0]  alt_eff;
  logic        rep;
  logic [31:0] match_next;

  assign hit_eff    = line_hit || found;
  assign alt_eff    = line_hit ? hit_alt : found_alt;
  assign rep        = hit_eff && !stopped;
  assign match_next = (rep && (match_cnt != mslm_pkg::COUNT_MAX)) ? match_cnt + 32'd1
                                                                   : match_cnt;

  always_comb begin
    res.line_matched        = rep;
    res.matched_alternative = rep ? alt_eff : 3'd0;
    res.line_number         = line_cnt;
    res.matching_lines      = match_next;
  end

  always_ff @(posedge clk) begin
    if (rst || step.restart) begin
      line_hit  <= 1'b0;
      hit_alt   <= '0;
      line_cnt  <= 32'd1;
      match_cnt <= '0;
      stopped   <= 1'b0;
    end else if (step.text) begin
      if (step.close) begin
        match_cnt <= match_next;
        if (rep && stop_first) begin
          stopped <= 1'b1;
        end
        if (line_cnt != mslm_pkg::COUNT_MAX) begin
          line_cnt <= line_cnt + 32'd1;
        end
        line_hit <= 1'b0;
        hit_alt  <= '0;
      end else begin
        line_hit <= hit_eff;
        hit_alt  <= alt_eff;
      end
    end
  end

`ifndef SYNTHESIS
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line_cnt != '0)
    else $error("line counter reached zero");
  a_stop_counted: assert property (@(posedge clk) disable iff (rst)
    stopped |-> (match_cnt != '0))
    else $error("search stopped without a counted matching line");
`endif

endmodule

/* rtl/multi_string_line_matcher_unit.sv */
// Top level of the multi-string line matcher: input register, configuration
// registers, output register. Uses mslm_pkg, mslm_if and the mslm_* submodules.
//
//   channel   kind         direction  payload
//   items     valid/ready  in         opcode, alt_index, position, value, end_of_text
//   results   valid/ready  out        line_matched, matched_alternative, line_number,
//                                     matching_lines
//   cfg       write only   in         cfg_we, cfg_index, cfg_data
//
// One word per cycle unless a pattern copy or a waiting result stalls; a text word
// passes the input register and its result the output register. A nonzero length word
// stalls the next word while the pattern row is copied out of the pattern memory.
// rst is synchronous; no clearing pass is needed after reset.
// A waiting result only stalls words that close a line.
module multi_string_line_matcher_unit #(
  parameter int MAX_ALTS = mslm_pkg::MAX_ALTS_DEFAULT,
  parameter int MAX_LEN  = mslm_pkg::MAX_LEN_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mslm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mslm_pkg::CFG_DATA_W-1:0]  cfg_data,
  mslm_item_if.sink                        items,
  mslm_result_if.source                    results
);

  localparam int AIW  = (MAX_ALTS > 1) ? $clog2(MAX_ALTS) : 1;
  localparam int LIW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LENW = $clog2(MAX_LEN + 1);

  logic [3:0]        num_alts;
  logic              case_fold;
  logic              stop_first;
  logic              iv;
  mslm_pkg::item_t   ir;
  logic              ov;
  mslm_pkg::result_t orr;
  mslm_pkg::result_t res;
  logic [7:0]        c;
  logic              nl;
  logic              close;
  logic              produces;
  logic              fire;
  logic              in_ready;
  logic              busy;
  logic              found;
  logic [2:0]        found_alt;
  mslm_pkg::step_t   step;
  mslm_pkg::pat_wr_t pw;
  logic [7:0]        rev [MAX_ALTS][MAX_LEN];
  logic [LENW-1:0]   lens [MAX_ALTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_alts   <= 4'd1;
      case_fold  <= 1'b0;
      stop_first <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mslm_pkg::CFG_NUM_ALTS:   num_alts   <= cfg_data[3:0];
        mslm_pkg::CFG_CASE_FOLD:  case_fold  <= cfg_data[0];
        mslm_pkg::CFG_STOP_FIRST: stop_first <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign c        = mslm_pkg::fold_byte(ir.value, case_fold);
  assign nl       = c == mslm_pkg::NEWLINE_BYTE;
  assign close    = ir.end_of_text || nl;
  assign produces = iv && (ir.opcode == mslm_pkg::OP_TEXT) && close;
  assign fire     = iv && !busy && (!produces || !ov || results.ready);
  assign in_ready = !iv || fire;
  assign items.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_ready) begin
      iv <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && items.valid) begin
      ir.opcode      <= items.opcode;
      ir.alt_index   <= items.alt_index;
      ir.position    <= items.position;
      ir.value       <= items.value;
      ir.end_of_text <= items.end_of_text;
    end
  end

  always_comb begin
    step.text      = fire && (ir.opcode == mslm_pkg::OP_TEXT);
    step.restart   = fire && (ir.opcode == mslm_pkg::OP_NEW_FILE);
    step.close     = close;
    step.newline   = nl;
    step.text_byte = c;
    pw.load_byte   = fire && (ir.opcode == mslm_pkg::OP_LOAD_BYTE);
    pw.set_len     = fire && (ir.opcode == mslm_pkg::OP_SET_LEN);
    pw.alt_index   = ir.alt_index;
    pw.position    = ir.position;
    pw.value       = ir.value;
  end

  mslm_pattern_store #(
    .MAX_ALTS (MAX_ALTS),
    .MAX_LEN  (MAX_LEN),
    .AIW      (AIW),
    .LIW      (LIW),
    .LENW     (LENW)
  ) u_pattern_store (
    .clk  (clk),
    .rst  (rst),
    .pw   (pw),
    .rev  (rev),
    .lens (lens),
    .busy (busy)
  );

  mslm_matcher #(
    .MAX_ALTS (MAX_ALTS),
    .MAX_LEN  (MAX_LEN),
    .LENW     (LENW)
  ) u_matcher (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .case_fold (case_fold),
    .num_alts  (num_alts),
    .rev       (rev),
    .lens      (lens),
    .found     (found),
    .found_alt (found_alt)
  );

  mslm_line_tracker u_line_tracker (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .stop_first (stop_first),
    .found      (found),
    .found_alt  (found_alt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (fire && produces) begin
      ov <= 1'b1;
    end else if (results.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produces) begin
      orr <= res;
    end
  end

  assign results.valid               = ov;
  assign results.line_matched        = orr.line_matched;
  assign results.matched_alternative = orr.matched_alternative;
  assign results.line_number         = orr.line_number;
  assign results.matching_lines      = orr.matching_lines;

`ifndef SYNTHESIS
  a_hold_in_copy: assert property (@(posedge clk) disable iff (rst)
    (iv && busy) |=> iv)
    else $error("word dropped while a pattern row was being copied");
`endif

endmodule

/* verif/multi_string_line_matcher_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for multi_string_line_matcher_unit: directed and random word streams with a
// word-level line-search predictor and an in-order check of every line report.
// Depends on rtl/mslm_pkg.sv, rtl/mslm_if.sv and the matcher RTL.
module multi_string_line_matcher_unit_tb;

  localparam int ALTS = mslm_pkg::MAX_ALTS_DEFAULT;
  localparam int WIN = mslm_pkg::MAX_LEN_DEFAULT;
  localparam int QUIET_LIMIT = 3000;
  localparam int CFG_SETTLE = 80;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [mslm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mslm_pkg::CFG_DATA_W-1:0] cfg_data;

  mslm_item_if item_ch();
  mslm_result_if result_ch();

  multi_string_line_matcher_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .items(item_ch),
    .results(result_ch)
  );

  logic [7:0] window_bytes [WIN];
  logic [7:0] pattern_rows [ALTS][WIN];
  bit row_written [ALTS][WIN];
  int alt_len [ALTS];
  bit line_has_hit;
  logic [2:0] first_alt;
  logic [31:0] line_no;
  logic [31:0] hit_lines;
  bit stopped;
  int bytes_in_line;
  logic [3:0] alt_count;
  bit fold_on;
  bit stop_on;

  mslm_pkg::result_t line_results[$];
  mslm_pkg::result_t want;
  int errors;
  int words_sent;
  int send_idle;
  int recv_idle;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    if (fold_on && b >= mslm_pkg::UPPER_A && b <= mslm_pkg::UPPER_Z)
      return b + mslm_pkg::FOLD_OFFSET;
    return b;
  endfunction

  function automatic bit alt_hits(input int a);
    int len;
    len = alt_len[a];
    if (len == 0 || len > bytes_in_line) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if (window_bytes[i] != fold_case(pattern_rows[a][len-1-i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void restart_file();
    for (int i = 0; i < WIN; i++) window_bytes[i] = mslm_pkg::NEWLINE_BYTE;
    line_has_hit = 1'b0;
    first_alt = '0;
    line_no = 32'd1;
    hit_lines = '0;
    stopped = 1'b0;
    bytes_in_line = 0;
  endfunction

  function automatic void take_text_byte(input logic [7:0] b, input logic eot);
    logic [7:0] c;
    bit hit;
    int n;
    mslm_pkg::result_t r;
    c = fold_case(b);
    for (int i = WIN - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
    window_bytes[0] = c;
    if (c != mslm_pkg::NEWLINE_BYTE) begin
      if (bytes_in_line < WIN) bytes_in_line++;
      if (!line_has_hit) begin
        n = (alt_count > ALTS) ? ALTS : alt_count;
        for (int a = n - 1; a >= 0 && !line_has_hit; a--) begin
          if (alt_hits(a)) begin
            line_has_hit = 1'b1;
            first_alt = 3'(a);
          end
        end
      end
    end
    if (eot || c == mslm_pkg::NEWLINE_BYTE) begin
      hit = line_has_hit && !stopped;
      if (hit) begin
        if (hit_lines != mslm_pkg::COUNT_MAX) hit_lines++;
        if (stop_on) stopped = 1'b1;
      end
      r.line_matched = hit;
      r.matched_alternative = hit ? first_alt : 3'd0;
      r.line_number = line_no;
      r.matching_lines = hit_lines;
      line_results.push_back(r);
      if (line_no != mslm_pkg::COUNT_MAX) line_no++;
      line_has_hit = 1'b0;
      first_alt = '0;
      bytes_in_line = 0;
    end
  endfunction

  function automatic void match_word(input mslm_pkg::item_t w);
    case (w.opcode)
      mslm_pkg::OP_LOAD_BYTE: begin
        pattern_rows[w.alt_index][w.position] = w.value;
        row_written[w.alt_index][w.position] = 1'b1;
      end
      mslm_pkg::OP_SET_LEN: alt_len[w.alt_index] = (w.value <= WIN) ? int'(w.value) : 0;
      mslm_pkg::OP_NEW_FILE: restart_file();
      default: take_text_byte(w.value, w.end_of_text);
    endcase
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [2:0] ai, input logic [5:0] pos,
                           input logic [7:0] val, input logic eot);
    mslm_pkg::item_t w;
    w.opcode = op;
    w.alt_index = ai;
    w.position = pos;
    w.value = val;
    w.end_of_text = eot;
    while ($urandom_range(99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.opcode <= op;
    item_ch.alt_index <= ai;
    item_ch.position <= pos;
    item_ch.value <= val;
    item_ch.end_of_text <= eot;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    match_word(w);
    words_sent++;
  endtask

  task automatic set_config(input logic [3:0] n, input bit fold, input bit stop);
    item_ch.valid <= 1'b0;
    while (line_results.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= mslm_pkg::CFG_NUM_ALTS;
    cfg_data <= n;
    @(posedge clk);
    cfg_index <= mslm_pkg::CFG_CASE_FOLD;
    cfg_data <= {3'b000, fold};
    @(posedge clk);
    cfg_index <= mslm_pkg::CFG_STOP_FIRST;
    cfg_data <= {3'b000, stop};
    @(posedge clk);
    cfg_we <= 1'b0;
    alt_count = n;
    fold_on = fold;
    stop_on = stop;
  endtask

  function automatic logic [7:0] pattern_byte();
    string alpha;
    alpha = "abcABC";
    if ($urandom_range(9) < 8) return alpha[$urandom_range(alpha.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  task automatic program_fixed(input int a, input string s);
    for (int i = 0; i < s.len(); i++)
      send_word(mslm_pkg::OP_LOAD_BYTE, 3'(a), 6'(i), s[i], 1'b0);
    send_word(mslm_pkg::OP_SET_LEN, 3'(a), 6'($urandom_range(63)), 8'(s.len()), 1'b0);
  endtask

  task automatic program_alt(input int a, input int len);
    for (int i = 0; i < len; i++)
      send_word(mslm_pkg::OP_LOAD_BYTE, 3'(a), 6'(i), pattern_byte(),
                1'($urandom_range(1)));
    send_word(mslm_pkg::OP_SET_LEN, 3'(a), 6'($urandom_range(63)), 8'(len),
              1'($urandom_range(1)));
  endtask

  // fill any unwritten byte under the new length first
  task automatic set_length(input int a, input int v);
    if (v >= 1 && v <= WIN) begin
      for (int i = 0; i < v; i++) begin
        if (!row_written[a][i])
          send_word(mslm_pkg::OP_LOAD_BYTE, 3'(a), 6'(i), pattern_byte(),
                    1'($urandom_range(1)));
      end
    end
    send_word(mslm_pkg::OP_SET_LEN, 3'(a), 6'($urandom_range(63)), 8'(v),
              1'($urandom_range(1)));
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++)
      send_word(mslm_pkg::OP_TEXT, 3'($urandom_range(7)), 6'($urandom_range(63)), s[i],
                eot_last && (i == s.len() - 1));
  endtask

  task automatic send_line();
    logic [7:0] line_q[$];
    logic [7:0] b;
    int n_pre;
    int a;
    int r;
    n_pre = ($urandom_range(19) == 0) ? $urandom_range(60, 80) : $urandom_range(0, 6);
    a = $urandom_range(ALTS - 1);
    for (int i = 0; i < n_pre; i++) line_q.push_back(pattern_byte());
    if ($urandom_range(9) < 7) begin
      for (int i = 0; i < alt_len[a]; i++) begin
        b = pattern_rows[a][i];
        if ((b | 8'h20) >= "a" && (b | 8'h20) <= "z" && $urandom_range(1)) b = b ^ 8'h20;
        line_q.push_back(b);
      end
    end
    repeat ($urandom_range(0, 4)) line_q.push_back(pattern_byte());
    r = $urandom_range(9);
    if (r < 6 || line_q.size() == 0) line_q.push_back(mslm_pkg::NEWLINE_BYTE);
    for (int i = 0; i < line_q.size(); i++)
      send_word(mslm_pkg::OP_TEXT, 3'($urandom_range(7)), 6'($urandom_range(63)), line_q[i],
                (i == line_q.size() - 1) && r >= 6);
  endtask

  task automatic send_noise();
    logic [1:0] op;
    op = 2'($urandom_range(3));
    if (op == mslm_pkg::OP_SET_LEN)
      set_length($urandom_range(ALTS - 1),
                 ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(0, 6));
    else
      send_word(op, 3'($urandom_range(7)), 6'($urandom_range(63)), 8'($urandom_range(255)),
                1'($urandom_range(1)));
  endtask

  task automatic random_config();
    logic [3:0] n;
    case ($urandom_range(9))
      0: n = 4'd0;
      1: n = 4'd15;
      2: n = 4'd1;
      3, 4, 5: n = 4'(ALTS);
      default: n = 4'($urandom_range(1, ALTS));
    endcase
    set_config(n, 1'($urandom_range(1)), $urandom_range(3) == 0);
  endtask

  task automatic test_alternative_priority();
    set_config(4'(ALTS), 1'b1, 1'b0);
    program_fixed(0, "a");
    program_fixed(1, "bA");
    send_text("xBa", 1'b1);
    send_text("\n", 1'b1);
  endtask

  task automatic test_disabled_alternatives();
    set_config(4'd15, 1'b0, 1'b0);
    send_text("b\nA\n", 1'b0);
    send_word(mslm_pkg::OP_SET_LEN, 3'd0, 6'd0, 8'hFF, 1'b0);
    send_word(mslm_pkg::OP_SET_LEN, 3'd1, 6'd63, 8'h00, 1'b0);
    program_fixed(7, "\n");
    send_text("a\n", 1'b0);
  endtask

  task automatic test_new_file();
    send_word(mslm_pkg::OP_SET_LEN, 3'd0, 6'd0, 8'd1, 1'b1);
    send_text("a", 1'b0);
    send_word(mslm_pkg::OP_NEW_FILE, 3'd7, 6'd63, 8'hFF, 1'b1);
    send_text("a\n", 1'b0);
  endtask

  task automatic test_stop_after_first();
    set_config(4'd0, 1'b0, 1'b1);
    send_text("a\n", 1'b0);
    set_config(4'd1, 1'b0, 1'b1);
    send_text("a\n", 1'b0);
    send_text("a\n", 1'b0);
  endtask

  task automatic test_random_traffic(input int s_idle, input int r_idle, input int count);
    int goal;
    int r;
    send_idle = s_idle;
    recv_idle = r_idle;
    goal = words_sent + count;
    while (words_sent < goal) begin
      r = $urandom_range(99);
      if (r < 58) send_line();
      else if (r < 72)
        program_alt($urandom_range(ALTS - 1),
                    ($urandom_range(29) == 0) ? WIN : $urandom_range(1, 5));
      else if (r < 88) send_noise();
      else if (r < 94)
        send_word(mslm_pkg::OP_NEW_FILE, 3'($urandom_range(7)), 6'($urandom_range(63)),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      else random_config();
    end
  endtask

  always @(posedge clk) result_ch.ready <= ($urandom_range(99) >= recv_idle);

  function automatic void check_field(input string what, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, what, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (line_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected line report: expected none actual %0b/%0d/%0d/%0d", $time,
                 result_ch.line_matched, result_ch.matched_alternative,
                 result_ch.line_number, result_ch.matching_lines);
      end else begin
        want = line_results.pop_front();
        check_field("line_matched", 32'(want.line_matched), 32'(result_ch.line_matched));
        check_field("matched_alternative", 32'(want.matched_alternative),
                    32'(result_ch.matched_alternative));
        check_field("line_number", want.line_number, result_ch.line_number);
        check_field("matching_lines", want.matching_lines, result_ch.matching_lines);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    words_sent = 0;
    send_idle = 0;
    recv_idle = 0;
    quiet_cycles = 0;
    for (int a = 0; a < ALTS; a++) begin
      alt_len[a] = 0;
      for (int i = 0; i < WIN; i++) begin
        pattern_rows[a][i] = '0;
        row_written[a][i] = 1'b0;
      end
    end
    alt_count = 4'd1;
    fold_on = 1'b0;
    stop_on = 1'b0;
    restart_file();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    item_ch.valid <= 1'b0;
    item_ch.opcode <= mslm_pkg::OP_LOAD_BYTE;
    item_ch.alt_index <= '0;
    item_ch.position <= '0;
    item_ch.value <= '0;
    item_ch.end_of_text <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_alternative_priority();
    test_disabled_alternatives();
    test_new_file();
    test_stop_after_first();
    set_config(4'(ALTS), 1'b0, 1'b0);
    test_random_traffic(9, 86, 520);
    test_random_traffic(86, 9, 520);
    test_random_traffic(0, 0, 520);

    item_ch.valid <= 1'b0;
    while (line_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
rtl/mslm_pkg.sv
rtl/mslm_if.sv
rtl/mslm_pattern_store.sv
rtl/mslm_matcher.sv
rtl/mslm_line_tracker.sv
rtl/multi_string_line_matcher_unit.sv
verif/multi_string_line_matcher_unit_tb.sv
